[design/sha256_stream_hasher_defines.svh]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shared property macros for the concurrent checks of the hasher.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SHS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("shs check failed");

// next-cycle implication, disabled while reset is asserted
`define SHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("shs check failed");

`endif

[design/shs_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Codes, sequencer states, round constants and round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

    localparam int WORD_W   = 32;
    localparam int DIGEST_W = 64;
    localparam int NUM_RND  = 64;

    localparam logic       KIND_ABSORB = 1'b0;
    localparam logic       KIND_FINISH = 1'b1;
    localparam logic       MODE_FULL   = 1'b0;
    localparam logic       MODE_FOLD   = 1'b1;
    localparam logic [7:0] PAD_BYTE    = 8'h80;
    // first fill position that leaves no room for the length field
    localparam logic [5:0] LEN_START   = 6'd56;
    localparam logic [5:0] LAST_BYTE   = 6'd63;
    localparam logic [5:0] LAST_RND    = 6'd63;
    localparam logic [1:0] LAST_OWORD  = 2'd3;
    localparam logic       REG_MODE    = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_COMP = 5'b00100,
        ST_ADD  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word ror32(input t_word x, input int n);
        logic [2*WORD_W-1:0] d;
        begin
            d = {x, x} >> n;
            return d[WORD_W-1:0];
        end
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word round_k(input logic [5:0] t);
        case (t)
            6'd0:  return 32'h428a2f98;  6'd1:  return 32'h71374491;
            6'd2:  return 32'hb5c0fbcf;  6'd3:  return 32'he9b5dba5;
            6'd4:  return 32'h3956c25b;  6'd5:  return 32'h59f111f1;
            6'd6:  return 32'h923f82a4;  6'd7:  return 32'hab1c5ed5;
            6'd8:  return 32'hd807aa98;  6'd9:  return 32'h12835b01;
            6'd10: return 32'h243185be;  6'd11: return 32'h550c7dc3;
            6'd12: return 32'h72be5d74;  6'd13: return 32'h80deb1fe;
            6'd14: return 32'h9bdc06a7;  6'd15: return 32'hc19bf174;
            6'd16: return 32'he49b69c1;  6'd17: return 32'hefbe4786;
            6'd18: return 32'h0fc19dc6;  6'd19: return 32'h240ca1cc;
            6'd20: return 32'h2de92c6f;  6'd21: return 32'h4a7484aa;
            6'd22: return 32'h5cb0a9dc;  6'd23: return 32'h76f988da;
            6'd24: return 32'h983e5152;  6'd25: return 32'ha831c66d;
            6'd26: return 32'hb00327c8;  6'd27: return 32'hbf597fc7;
            6'd28: return 32'hc6e00bf3;  6'd29: return 32'hd5a79147;
            6'd30: return 32'h06ca6351;  6'd31: return 32'h14292967;
            6'd32: return 32'h27b70a85;  6'd33: return 32'h2e1b2138;
            6'd34: return 32'h4d2c6dfc;  6'd35: return 32'h53380d13;
            6'd36: return 32'h650a7354;  6'd37: return 32'h766a0abb;
            6'd38: return 32'h81c2c92e;  6'd39: return 32'h92722c85;
            6'd40: return 32'ha2bfe8a1;  6'd41: return 32'ha81a664b;
            6'd42: return 32'hc24b8b70;  6'd43: return 32'hc76c51a3;
            6'd44: return 32'hd192e819;  6'd45: return 32'hd6990624;
            6'd46: return 32'hf40e3585;  6'd47: return 32'h106aa070;
            6'd48: return 32'h19a4c116;  6'd49: return 32'h1e376c08;
            6'd50: return 32'h2748774c;  6'd51: return 32'h34b0bcb5;
            6'd52: return 32'h391c0cb3;  6'd53: return 32'h4ed8aa4a;
            6'd54: return 32'h5b9cca4f;  6'd55: return 32'h682e6ff3;
            6'd56: return 32'h748f82ee;  6'd57: return 32'h78a5636f;
            6'd58: return 32'h84c87814;  6'd59: return 32'h8cc70208;
            6'd60: return 32'h90befffa;  6'd61: return 32'ha4506ceb;
            6'd62: return 32'hbef9a3f7;  6'd63: return 32'hc67178f2;
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

[design/shs_ifs.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher channels
// Valid/ready channel interfaces for the input items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface shs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface shs_out_if;
    logic                          valid;
    logic                          ready;
    logic [shs_pkg::DIGEST_W-1:0]  digest_word;
    logic                          last_word;

    modport source (output valid, output digest_word, output last_word, input ready);
    modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

`default_nettype wire

[design/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide SHA-256 with a single iterated round unit and APB mode register.
// ----------------------------------------------------------------------------
// An absorb byte leaves the input ready for the next byte, except the 64th
// byte of a block, which starts a compression (64 rounds, then the
// feed-forward add). A finish runs a pad step and a compression, plus a
// second one when fewer than 9 bytes of room remain in the last block, then
// presents four 64-bit digest words (or one XOR fold in fold mode), one per
// cycle while the sink takes them. The single round unit does one round per
// cycle; the input is not ready while it runs or while results are pending.
// After the last result the chaining value, byte count and bit count return
// to their initial values; the output mode is kept.
`default_nettype none

`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    shs_in_if.sink           i_in,
    shs_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    shs_pkg::t_state r_state, n_state;
    shs_pkg::t_word  r_h [8];
    shs_pkg::t_word  n_h [8];
    shs_pkg::t_word  r_v [8];
    shs_pkg::t_word  n_v [8];
    shs_pkg::t_word  r_w [16];
    shs_pkg::t_word  n_w [16];
    shs_pkg::t_word  sum_h [8];
    logic [5:0]      r_fill, n_fill;
    logic [63:0]     r_bits, n_bits;
    logic [5:0]      r_round, n_round;
    logic            r_fin, n_fin;
    logic            r_extra, n_extra;
    logic [1:0]      r_k, n_k;
    logic            r_mode;

    logic            in_fire;
    logic            out_fire;
    logic            cfg_wr;
    logic            last_res;
    logic [5:0]      pos;
    shs_pkg::t_word  w_new;
    shs_pkg::t_word  t1;
    shs_pkg::t_word  t2;
    logic [63:0]     fold;
    logic [63:0]     full_word;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == shs_pkg::REG_MODE);
    assign prdata = (paddr[2] == shs_pkg::REG_MODE) ? {31'b0, r_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= shs_pkg::MODE_FULL;
        end else if (cfg_wr) begin
            r_mode <= pwdata[0];
        end
    end

    // ---------------- handshakes ----------------
    assign i_in.ready  = (r_state == shs_pkg::ST_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = (r_state == shs_pkg::ST_OUT);
    assign out_fire    = o_out.valid && o_out.ready;

    assign last_res  = (r_mode == shs_pkg::MODE_FOLD) || (r_k == shs_pkg::LAST_OWORD);
    assign fold      = {r_h[0], r_h[1]} ^ {r_h[2], r_h[3]} ^ {r_h[4], r_h[5]}
                     ^ {r_h[6], r_h[7]};
    assign full_word = {r_h[{r_k, 1'b0}], r_h[{r_k, 1'b1}]};

    assign o_out.digest_word = (r_mode == shs_pkg::MODE_FOLD) ? fold : full_word;
    assign o_out.last_word   = last_res;

    // ---------------- round unit ----------------
    assign w_new = shs_pkg::small_sigma1(r_w[14]) + r_w[9]
                 + shs_pkg::small_sigma0(r_w[1]) + r_w[0];
    assign t1 = r_v[7] + shs_pkg::big_sigma1(r_v[4])
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + shs_pkg::round_k(r_round) + r_w[0];
    assign t2 = shs_pkg::big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sum_h[i] = r_h[i] + r_v[i];
        end
    end

    // ---------------- message window ----------------
    always_comb begin
        n_w = r_w;
        pos = '0;
        case (r_state)
            shs_pkg::ST_IDLE: begin
                if (in_fire && (i_in.kind == shs_pkg::KIND_ABSORB)) begin
                    for (int b = 0; b < 4; b++) begin
                        if (r_fill[1:0] == 2'(b)) begin
                            n_w[r_fill[5:2]][31-8*b -: 8] = i_in.data_byte;
                        end
                    end
                end
            end
            shs_pkg::ST_PAD: begin
                // marker byte at the fill point, zeros after it
                for (int j = 0; j < 16; j++) begin
                    for (int b = 0; b < 4; b++) begin
                        pos = 6'(4*j + b);
                        if (pos == r_fill) begin
                            n_w[j][31-8*b -: 8] = shs_pkg::PAD_BYTE;
                        end else if (pos > r_fill) begin
                            n_w[j][31-8*b -: 8] = 8'h00;
                        end
                    end
                end
                if (r_fill < shs_pkg::LEN_START) begin
                    n_w[14] = r_bits[63:32];
                    n_w[15] = r_bits[31:0];
                end
            end
            shs_pkg::ST_COMP: begin
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[15] = w_new;
            end
            shs_pkg::ST_ADD: begin
                // length-only block after an overflowing pad
                if (r_fin && r_extra) begin
                    for (int i = 0; i < 14; i++) begin
                        n_w[i] = '0;
                    end
                    n_w[14] = r_bits[63:32];
                    n_w[15] = r_bits[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_v <= n_v;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_v     = r_v;
        n_fill  = r_fill;
        n_bits  = r_bits;
        n_round = r_round;
        n_fin   = r_fin;
        n_extra = r_extra;
        n_k     = r_k;
        case (r_state)
            shs_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.kind == shs_pkg::KIND_ABSORB) begin
                        n_bits = r_bits + 64'd8;
                        n_fill = r_fill + 6'd1;
                        if (r_fill == shs_pkg::LAST_BYTE) begin
                            n_v     = r_h;
                            n_round = '0;
                            n_fin   = 1'b0;
                            n_state = shs_pkg::ST_COMP;
                        end
                    end else begin
                        n_fin   = 1'b1;
                        n_state = shs_pkg::ST_PAD;
                    end
                end
            end
            shs_pkg::ST_PAD: begin
                n_extra = (r_fill >= shs_pkg::LEN_START);
                n_v     = r_h;
                n_round = '0;
                n_state = shs_pkg::ST_COMP;
            end
            shs_pkg::ST_COMP: begin
                for (int i = 7; i > 0; i--) begin
                    n_v[i] = r_v[i-1];
                end
                n_v[4]  = r_v[3] + t1;
                n_v[0]  = t1 + t2;
                n_round = r_round + 6'd1;
                if (r_round == shs_pkg::LAST_RND) begin
                    n_state = shs_pkg::ST_ADD;
                end
            end
            shs_pkg::ST_ADD: begin
                n_h = sum_h;
                if (!r_fin) begin
                    n_state = shs_pkg::ST_IDLE;
                end else if (r_extra) begin
                    n_extra = 1'b0;
                    n_v     = sum_h;
                    n_round = '0;
                    n_state = shs_pkg::ST_COMP;
                end else begin
                    n_k     = '0;
                    n_state = shs_pkg::ST_OUT;
                end
            end
            shs_pkg::ST_OUT: begin
                if (out_fire) begin
                    if (last_res) begin
                        n_h     = shs_pkg::INIT_HASH;
                        n_fill  = '0;
                        n_bits  = '0;
                        n_fin   = 1'b0;
                        n_state = shs_pkg::ST_IDLE;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            default: begin
                n_state = shs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shs_pkg::ST_IDLE;
            r_h     <= shs_pkg::INIT_HASH;
            r_fill  <= '0;
            r_bits  <= '0;
            r_round <= '0;
            r_fin   <= 1'b0;
            r_extra <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
            r_round <= n_round;
            r_fin   <= n_fin;
            r_extra <= n_extra;
            r_k     <= n_k;
        end
    end

    // ---------------- checks ----------------
    `SHS_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `SHS_ASSERT_NEXT(a_rounds_end, i_clk, i_rst_n, (r_state == shs_pkg::ST_COMP) && (r_round == shs_pkg::LAST_RND), r_state == shs_pkg::ST_ADD)
    `SHS_ASSERT_NEXT(a_restart, i_clk, i_rst_n, out_fire && last_res, (r_state == shs_pkg::ST_IDLE) && (r_fill == 6'd0) && (r_bits == 64'd0))
    `SHS_ASSERT_NEXT(a_byte_fast, i_clk, i_rst_n, in_fire && (i_in.kind == shs_pkg::KIND_ABSORB) && (r_fill != shs_pkg::LAST_BYTE), i_in.ready)

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte messages and finish commands with random bursts and output
// stalls, predicts every digest word in a local SHA-256 model and checks
// full and fold output modes, padding across one and two blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int CYCLE_LIMIT = 1000000;
    // worst case busy time after an absorb transfer that fills a block
    localparam int BUSY_CYCLES = 80;
    // finish with two compressions plus margin
    localparam int TAIL_CYCLES = 160;
    localparam int RAND_ITEMS  = 250;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [63:0] word;
        logic        last;
    } t_digest_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    shs_in_if  in_if ();
    shs_out_if out_if ();

    sha256_stream_hasher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // local hash state
    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    int unsigned  block_cnt;
    logic [63:0]  msg_bits;
    logic         fold_mode;

    t_digest_item digest_q [$];
    t_digest_item got_exp;

    int fail_count   = 0;
    int items_sent   = 0;
    int burst_left   = 0;
    int cycle_count  = 0;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void hash_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        int          t;
        for (t = 0; t < 16; t++) begin
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        end
        for (t = 16; t < 64; t++) begin
            w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
                   (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        end
        for (t = 0; t < 8; t++) v[t] = hash_state[t];
        for (t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
                 ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
                 ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (t = 0; t < 8; t++) hash_state[t] = hash_state[t] + v[t];
    endfunction

    function automatic void restart_hash();
        int i;
        for (i = 0; i < 8; i++) hash_state[i] = SHA_H0[i];
        block_cnt = 0;
        msg_bits  = '0;
    endfunction

    // append one expected result at the tail of the queue
    function automatic void queue_result(input t_digest_item item);
        digest_q.insert(digest_q.size(), item);
    endfunction

    function automatic void absorb_byte(input logic [7:0] data);
        msg_block[block_cnt] = data;
        msg_bits  = msg_bits + 64'd8;
        block_cnt = block_cnt + 1;
        if (block_cnt == 64) begin
            hash_block();
            block_cnt = 0;
        end
    endfunction

    function automatic void finish_message();
        logic [63:0]  words [4];
        logic [63:0]  fold;
        t_digest_item item;
        int           i;
        msg_block[block_cnt] = shs_pkg::PAD_BYTE;
        for (i = block_cnt + 1; i < 64; i++) msg_block[i] = 8'h00;
        // no room for the length: close this block and pad a fresh one
        if (block_cnt >= 56) begin
            hash_block();
            for (i = 0; i < 64; i++) msg_block[i] = 8'h00;
        end
        for (i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
        hash_block();
        fold = '0;
        for (i = 0; i < 4; i++) begin
            words[i] = {hash_state[2*i], hash_state[2*i+1]};
            fold ^= words[i];
        end
        if (fold_mode == shs_pkg::MODE_FOLD) begin
            item.word = fold;
            item.last = 1'b1;
            queue_result(item);
        end else begin
            for (i = 0; i < 4; i++) begin
                item.word = words[i];
                item.last = (i == 3);
                queue_result(item);
            end
        end
        restart_hash();
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result sink: a randomly chosen stall pattern, redrawn after each random-length run
    initial begin
        int stall_kind;
        int kind_left;
        stall_kind = 0;
        kind_left  = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (kind_left == 0) begin
                stall_kind = $urandom_range(0, 3);
                kind_left  = $urandom_range(8, 64);
            end
            kind_left--;
            case (stall_kind)
                2: begin
                    out_if.ready <= ($urandom_range(0, 2) != 0);
                end
                3: begin
                    out_if.ready <= (kind_left % 8 == 0);
                end
                default: begin
                    out_if.ready <= 1'b1;
                end
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (digest_q.size() == 0) begin
                $error("digest_word: no result expected, actual %h", out_if.digest_word);
                fail_count++;
            end else begin
                got_exp = digest_q.pop_front();
                if (out_if.digest_word !== got_exp.word) begin
                    $error("digest_word: expected %h, actual %h",
                           got_exp.word, out_if.digest_word);
                    fail_count++;
                end
                if (out_if.last_word !== got_exp.last) begin
                    $error("last_word: expected %0d, actual %0d",
                           got_exp.last, out_if.last_word);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] data);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        in_if.valid     <= 1'b1;
        in_if.kind      <= kind;
        in_if.data_byte <= data;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        burst_left--;
        items_sent++;
        if (kind == shs_pkg::KIND_ABSORB) absorb_byte(data);
        else finish_message();
    endtask

    // hold off until every result is in and any block compression is over
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (BUSY_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_output_mode(input logic mode);
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {shs_pkg::REG_MODE, 2'b00};
        pwdata  <= {31'd0, mode};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        fold_mode = mode;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_message(input int len);
        int          i;
        logic [7:0]  data;
        for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
                0:       data = 8'h00;
                1:       data = 8'hff;
                default: data = 8'($urandom_range(0, 255));
            endcase
            send_item(shs_pkg::KIND_ABSORB, data);
        end
        send_item(shs_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_empty_message();
        set_output_mode(shs_pkg::MODE_FULL);
        send_item(shs_pkg::KIND_FINISH, 8'h00);
    endtask

    task automatic test_short_messages();
        send_item(shs_pkg::KIND_ABSORB, 8'h61);
        send_item(shs_pkg::KIND_ABSORB, 8'h62);
        send_item(shs_pkg::KIND_ABSORB, 8'h63);
        send_item(shs_pkg::KIND_FINISH, 8'h00);
        // byte extremes; finish byte must be ignored
        send_item(shs_pkg::KIND_ABSORB, 8'h00);
        send_item(shs_pkg::KIND_ABSORB, 8'hff);
        send_item(shs_pkg::KIND_ABSORB, 8'h80);
        send_item(shs_pkg::KIND_FINISH, 8'hff);
    endtask

    task automatic test_fold_mode();
        set_output_mode(shs_pkg::MODE_FOLD);
        send_item(shs_pkg::KIND_FINISH, 8'h5a);
        send_item(shs_pkg::KIND_ABSORB, 8'h61);
        send_item(shs_pkg::KIND_ABSORB, 8'h62);
        send_item(shs_pkg::KIND_ABSORB, 8'h63);
        send_item(shs_pkg::KIND_FINISH, 8'ha5);
        set_output_mode(shs_pkg::MODE_FULL);
    endtask

    task automatic test_random_messages();
        int len;
        while (items_sent < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                5, 6:    len = $urandom_range(50, 66);
                7:       len = 0;
                8:       len = $urandom_range(110, 130);
                9: begin
                    case ($urandom_range(0, 3))
                        0:       len = 55;
                        1:       len = 56;
                        2:       len = 64;
                        default: len = 128;
                    endcase
                end
                default: len = $urandom_range(1, 20);
            endcase
            // trim the last message so the run stays near the item budget
            if (items_sent + len + 1 > RAND_ITEMS) len = RAND_ITEMS - items_sent - 1;
            send_message(len);
            if ($urandom_range(0, 5) == 0) set_output_mode(1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.kind      = shs_pkg::KIND_ABSORB;
        in_if.data_byte = 8'h00;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        fold_mode       = shs_pkg::MODE_FULL;
        restart_hash();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_short_messages();
        test_fold_mode();
        test_random_messages();

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sha256_stream_hasher.f]
+incdir+design
design/shs_pkg.sv
design/shs_ifs.sv
design/sha256_stream_hasher.sv
tb/tb.sv
